// ----- src/dts_pkg.sv -----
// Package for the dependency-counting task scheduler.
// Sizes, task state, op and status codes, payload and record types, move table.
// No dependencies.
package dts_pkg;

    localparam int TASKS = 64;
    localparam int IDX_W = $clog2(TASKS);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [3:0] ST_PENDING    = 4'd0;
    localparam logic [3:0] ST_READY      = 4'd1;
    localparam logic [3:0] ST_DISPATCHED = 4'd2;
    localparam logic [3:0] ST_RUNNING    = 4'd3;
    localparam logic [3:0] ST_COMPLETED  = 4'd4;
    localparam logic [3:0] ST_FAILED     = 4'd5;
    localparam logic [3:0] ST_TIMED_OUT  = 4'd6;
    localparam logic [3:0] ST_DEAD       = 4'd7;
    localparam logic [3:0] ST_CASCADE    = 4'd8;

    localparam logic [2:0] OP_ADD_EDGE  = 3'd0;
    localparam logic [2:0] OP_START     = 3'd1;
    localparam logic [2:0] OP_TRANSIT   = 3'd2;
    localparam logic [2:0] OP_NOTIFY    = 3'd3;
    localparam logic [2:0] OP_PROPAGATE = 3'd4;
    localparam logic [2:0] OP_ENQUEUE   = 3'd5;
    localparam logic [2:0] OP_DEQUEUE   = 3'd6;
    localparam logic [2:0] OP_QUERY     = 3'd7;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_STALE    = 3'd1;
    localparam logic [2:0] STS_ILLEGAL  = 3'd2;
    localparam logic [2:0] STS_EMPTY    = 3'd3;
    localparam logic [2:0] STS_OVERFLOW = 3'd4;
    localparam logic [2:0] STS_BAD_EDGE = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] task_req;
        logic [5:0] parent_task;
        logic [3:0] expected_state;
        logic [3:0] next_state;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  task_out;
        logic [3:0]  state_out;
        logic [15:0] generation_out;
        logic [7:0]  retry_out;
        logic [6:0]  ready_depth;
        logic        all_finished;
    } t_out;

    typedef struct packed {
        logic [3:0]  state;
        logic [6:0]  parent_count;
        logic [6:0]  parents_done;
        logic [15:0] generation;
        logic [7:0]  retries;
    } t_rec;

    function automatic logic move_legal(input logic [3:0] from, input logic [3:0] to);
        logic r;
        r = 1'b0;
        case (from)
            ST_PENDING:    r = (to == ST_READY) || (to == ST_CASCADE);
            ST_READY:      r = (to == ST_DISPATCHED) || (to == ST_CASCADE);
            ST_DISPATCHED: r = (to == ST_RUNNING) || (to == ST_FAILED) || (to == ST_TIMED_OUT);
            ST_RUNNING:    r = (to == ST_COMPLETED) || (to == ST_FAILED)
                               || (to == ST_TIMED_OUT);
            ST_FAILED,
            ST_TIMED_OUT:  r = (to == ST_READY) || (to == ST_DEAD);
            default:       r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_finished(input logic [3:0] s);
        return (s == ST_COMPLETED) || (s == ST_DEAD) || (s == ST_CASCADE);
    endfunction

endpackage

// ----- src/dts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// A read of the address written in the same cycle returns the new data.
// No dependencies.
module dts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            o_rdata <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ----- src/dag_task_scheduler.sv -----
// Top level of the dependency-counting task scheduler: sequencer, task
// record RAM, child map RAM and ready ring RAM. Uses dts_pkg and dts_ram.
//
//  channel   direction  signals                          transfer when
//  in        to block   i_in_valid / o_in_ready, i_in    valid & ready
//  out       from block o_out_valid / i_out_ready, o_out valid & ready
//  cfg       to block   i_cfg_we, i_cfg_data             i_cfg_we
//
// One op at a time; o_in_ready is high only when the sequencer is idle.
// Start and notify walk the slots in use, one slot a cycle; propagate_dead
// walks them once per round, one round per level of the cascade.
// Reset (synchronous, active low) clears control, ring pointers and the
// per-entry valid bits; no clearing pass is needed.
// A stalled result sits in the output register and holds the sequencer.
module dag_task_scheduler (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  dts_pkg::t_in                 i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output dts_pkg::t_out                o_out,
    input  logic                         i_cfg_we,
    input  logic [dts_pkg::CNT_W-1:0]    i_cfg_data
);
    localparam int IW = dts_pkg::IDX_W;
    localparam int CW = dts_pkg::CNT_W;
    localparam int N  = dts_pkg::TASKS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ADD_M = 4'd1;
    localparam logic [3:0] S_ADD_R = 4'd2;
    localparam logic [3:0] S_START = 4'd3;
    localparam logic [3:0] S_TRANS = 4'd4;
    localparam logic [3:0] S_NT_M  = 4'd5;
    localparam logic [3:0] S_NT    = 4'd6;
    localparam logic [3:0] S_PD_M  = 4'd7;
    localparam logic [3:0] S_PD    = 4'd8;
    localparam logic [3:0] S_DEQ   = 4'd9;
    localparam logic [3:0] S_RPT   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    // sequencer
    logic [3:0]    r_state, n_state;
    dts_pkg::t_in  r_cmd, n_cmd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [2:0]    r_status, n_status;
    logic [IW-1:0] r_tout, n_tout;
    logic          r_report, n_report;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_addr, n_addr;
    logic [N-1:0]  r_front, n_front;
    logic [N-1:0]  r_next, n_next;

    // per-entry valid bits and finished tracking
    logic [N-1:0]  r_rec_v, n_rec_v;
    logic [N-1:0]  r_map_v, n_map_v;
    logic [N-1:0]  r_unfin, n_unfin;

    // ready ring
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    // output register
    logic          r_out_valid, n_out_valid;
    dts_pkg::t_out r_out, n_out;

    // RAM ports
    logic                 rec_we;
    dts_pkg::t_rec        rec_wd;
    logic [$bits(dts_pkg::t_rec)-1:0] rec_rd;
    logic                 map_we;
    logic [N-1:0]         map_wd;
    logic [N-1:0]         map_rd;
    logic                 ring_we;
    logic [IW-1:0]        ring_rd;

    // shared datapath
    dts_pkg::t_rec rec;
    logic [N-1:0]  row;
    logic [N-1:0]  cnt_mask;
    logic          last;
    logic          push_en;
    logic [IW-1:0] push_slot;
    logic          full;
    logic          ok_req;
    logic [N-1:0]  pd_next;

    dts_ram #(.WIDTH($bits(dts_pkg::t_rec)), .DEPTH(N)) u_rec (
        .i_clk  (i_clk),
        .i_we   (rec_we),
        .i_waddr(r_addr),
        .i_wdata(rec_wd),
        .i_raddr(n_addr),
        .o_rdata(rec_rd)
    );

    dts_ram #(.WIDTH(N), .DEPTH(N)) u_map (
        .i_clk  (i_clk),
        .i_we   (map_we),
        .i_waddr(r_addr),
        .i_wdata(map_wd),
        .i_raddr(n_addr),
        .o_rdata(map_rd)
    );

    dts_ram #(.WIDTH(IW), .DEPTH(N)) u_ring (
        .i_clk  (i_clk),
        .i_we   (ring_we),
        .i_waddr(r_tail),
        .i_wdata(push_slot),
        .i_raddr(r_head),
        .o_rdata(ring_rd)
    );

    // slots in use
    always_comb begin
        for (int k = 0; k < N; k++) begin
            cnt_mask[k] = (CW'(k) < r_cnt);
        end
    end

    // never-written entries read as their reset value
    assign rec    = r_rec_v[r_addr] ? dts_pkg::t_rec'(rec_rd) : '0;
    assign row    = r_map_v[r_addr] ? map_rd : '0;
    assign last   = (({1'b0, r_i} + CW'(1)) >= r_cnt);
    assign full   = (r_count == CW'(N));
    assign ok_req = ({1'b0, i_in.task_req} < r_cnt);
    assign pd_next = (r_next | row) & cnt_mask;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_cnt       = r_cnt;
        n_status    = r_status;
        n_tout      = r_tout;
        n_report    = r_report;
        n_i         = r_i;
        n_addr      = r_addr;
        n_front     = r_front;
        n_next      = r_next;
        n_rec_v     = r_rec_v;
        n_map_v     = r_map_v;
        n_unfin     = r_unfin;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        rec_we      = 1'b0;
        rec_wd      = rec;
        map_we      = 1'b0;
        map_wd      = row;
        push_en     = 1'b0;
        push_slot   = r_addr;
        ring_we     = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // register write, clamped to 1..TASKS
        if (i_cfg_we) begin
            if (i_cfg_data == '0) begin
                n_cnt = CW'(1);
            end else if (i_cfg_data > CW'(N)) begin
                n_cnt = CW'(N);
            end else begin
                n_cnt = i_cfg_data;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = i_in;
                    n_status = dts_pkg::STS_OK;
                    n_tout   = i_in.task_req;
                    n_report = ok_req;
                    n_i      = '0;
                    n_state  = S_RPT;
                    unique case (i_in.op)
                        dts_pkg::OP_ADD_EDGE: begin
                            if (!ok_req || ({1'b0, i_in.parent_task} >= r_cnt)
                                || (i_in.parent_task == i_in.task_req)) begin
                                n_status = dts_pkg::STS_BAD_EDGE;
                            end else begin
                                n_addr  = i_in.parent_task;
                                n_state = S_ADD_M;
                            end
                        end
                        dts_pkg::OP_START: begin
                            n_tout   = '0;
                            n_report = 1'b0;
                            n_addr   = '0;
                            n_state  = S_START;
                        end
                        dts_pkg::OP_TRANSIT: begin
                            if (!ok_req) begin
                                n_status = dts_pkg::STS_ILLEGAL;
                            end else begin
                                n_addr  = i_in.task_req;
                                n_state = S_TRANS;
                            end
                        end
                        dts_pkg::OP_NOTIFY: begin
                            if (!ok_req) begin
                                n_status = dts_pkg::STS_ILLEGAL;
                            end else begin
                                n_addr  = i_in.task_req;
                                n_state = S_NT_M;
                            end
                        end
                        dts_pkg::OP_PROPAGATE: begin
                            if (!ok_req) begin
                                n_status = dts_pkg::STS_ILLEGAL;
                            end else begin
                                n_addr  = i_in.task_req;
                                n_state = S_PD_M;
                            end
                        end
                        dts_pkg::OP_ENQUEUE: begin
                            if (!ok_req) begin
                                n_status = dts_pkg::STS_ILLEGAL;
                            end else begin
                                push_en   = 1'b1;
                                push_slot = i_in.task_req;
                            end
                        end
                        dts_pkg::OP_DEQUEUE: begin
                            if (r_count == '0) begin
                                n_status = dts_pkg::STS_EMPTY;
                                n_tout   = '0;
                                n_report = 1'b0;
                            end else begin
                                n_state = S_DEQ;
                            end
                        end
                        dts_pkg::OP_QUERY: begin
                            if (!ok_req) begin
                                n_status = dts_pkg::STS_ILLEGAL;
                            end
                        end
                        default: n_state = S_RPT;
                    endcase
                end
            end

            S_ADD_M: begin
                if (row[r_cmd.task_req]) begin
                    n_status = dts_pkg::STS_BAD_EDGE;
                    n_state  = S_RPT;
                end else begin
                    map_we           = 1'b1;
                    map_wd           = row | (N'(1) << r_cmd.task_req);
                    n_map_v[r_addr]  = 1'b1;
                    n_addr           = r_cmd.task_req;
                    n_state          = S_ADD_R;
                end
            end

            S_ADD_R: begin
                rec_we = 1'b1;
                if (rec.parent_count != 7'h7F) begin
                    rec_wd.parent_count = rec.parent_count + 7'd1;
                end
                n_rec_v[r_addr] = 1'b1;
                n_state         = S_RPT;
            end

            S_START: begin
                if (rec.parent_count == '0) begin
                    rec_we          = 1'b1;
                    rec_wd.state    = dts_pkg::ST_READY;
                    n_rec_v[r_addr] = 1'b1;
                    n_unfin[r_addr] = 1'b1;
                    push_en         = 1'b1;
                end
                if (last) begin
                    n_state = S_RPT;
                end else begin
                    n_i    = r_i + IW'(1);
                    n_addr = r_i + IW'(1);
                end
            end

            S_TRANS: begin
                n_state = S_RPT;
                if (rec.state != r_cmd.expected_state) begin
                    n_status = dts_pkg::STS_STALE;
                end else if (!dts_pkg::move_legal(rec.state, r_cmd.next_state)) begin
                    n_status = dts_pkg::STS_ILLEGAL;
                end else begin
                    rec_we       = 1'b1;
                    rec_wd.state = r_cmd.next_state;
                    // retry move: new generation, one more retry
                    if ((r_cmd.next_state == dts_pkg::ST_READY)
                        && ((rec.state == dts_pkg::ST_FAILED)
                            || (rec.state == dts_pkg::ST_TIMED_OUT))) begin
                        rec_wd.generation = rec.generation + 16'd1;
                        if (rec.retries != 8'hFF) begin
                            rec_wd.retries = rec.retries + 8'd1;
                        end
                    end
                    n_rec_v[r_addr] = 1'b1;
                    n_unfin[r_addr] = !dts_pkg::is_finished(r_cmd.next_state);
                end
            end

            S_NT_M: begin
                n_front = row & cnt_mask;
                n_addr  = '0;
                n_state = S_NT;
            end

            S_NT: begin
                if (r_front[r_i]) begin
                    rec_we = 1'b1;
                    if (rec.parents_done != 7'h7F) begin
                        rec_wd.parents_done = rec.parents_done + 7'd1;
                    end
                    if ((rec_wd.parents_done == rec.parent_count)
                        && (rec.state == dts_pkg::ST_PENDING)) begin
                        rec_wd.state    = dts_pkg::ST_READY;
                        n_unfin[r_addr] = 1'b1;
                        push_en         = 1'b1;
                    end
                    n_rec_v[r_addr] = 1'b1;
                end
                if (last) begin
                    n_state = S_RPT;
                end else begin
                    n_i    = r_i + IW'(1);
                    n_addr = r_i + IW'(1);
                end
            end

            S_PD_M: begin
                n_front = row & cnt_mask;
                n_next  = '0;
                n_addr  = '0;
                n_state = S_PD;
            end

            // one frontier round: slot r_i, its record and child row
            S_PD: begin
                if (r_front[r_i] && ((rec.state == dts_pkg::ST_PENDING)
                                     || (rec.state == dts_pkg::ST_READY))) begin
                    rec_we          = 1'b1;
                    rec_wd.state    = dts_pkg::ST_CASCADE;
                    n_rec_v[r_addr] = 1'b1;
                    n_unfin[r_addr] = 1'b0;
                    n_next          = r_next | row;
                end
                if (last) begin
                    if ((rec_we ? pd_next : (r_next & cnt_mask)) != '0) begin
                        n_front = rec_we ? pd_next : (r_next & cnt_mask);
                        n_next  = '0;
                        n_i     = '0;
                        n_addr  = '0;
                    end else begin
                        n_state = S_RPT;
                    end
                end else begin
                    n_i    = r_i + IW'(1);
                    n_addr = r_i + IW'(1);
                end
            end

            S_DEQ: begin
                n_tout   = ring_rd;
                n_report = 1'b1;
                n_head   = r_head + IW'(1);
                n_count  = r_count - CW'(1);
                n_state  = S_RPT;
            end

            S_RPT: begin
                n_addr  = r_tout;
                n_state = S_OUT;
            end

            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.status         = r_status;
                    n_out.task_out       = r_tout;
                    n_out.state_out      = r_report ? rec.state : '0;
                    n_out.generation_out = r_report ? rec.generation : '0;
                    n_out.retry_out      = r_report ? rec.retries : '0;
                    n_out.ready_depth    = r_count;
                    n_out.all_finished   = ((r_unfin & cnt_mask) == '0);
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        // ring push, dropped when full
        if (push_en) begin
            if (full) begin
                n_status = dts_pkg::STS_OVERFLOW;
            end else begin
                ring_we = 1'b1;
                n_tail  = r_tail + IW'(1);
                n_count = r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= CW'(1);
            r_rec_v     <= '0;
            r_map_v     <= '0;
            r_unfin     <= '1;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_addr      <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rec_v     <= n_rec_v;
            r_map_v     <= n_map_v;
            r_unfin     <= n_unfin;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_addr      <= n_addr;
        end
        r_cmd    <= n_cmd;
        r_status <= n_status;
        r_tout   <= n_tout;
        r_report <= n_report;
        r_i      <= n_i;
        r_front  <= n_front;
        r_next   <= n_next;
        r_out    <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- src/dts_checker.sv -----
// Port-level checks for the task scheduler, bound to the top level.
// Uses dts_pkg.
module dts_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input dts_pkg::t_out             o_out
);
    // held result stays put until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("result changed while stalled");

    // one op at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while busy");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.ready_depth <= 7'(dts_pkg::TASKS)))
        else $error("ring depth beyond task slots");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status == dts_pkg::STS_EMPTY))
        |-> ((o_out.ready_depth == '0) && (o_out.task_out == '0)))
        else $error("empty answer with entries in ring");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
endmodule

bind dag_task_scheduler dts_checker u_dts_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out      (o_out)
);
